// ===== rtl/sorted_unique_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_unique_key_table_macros: assertion macros
// Clocked implication checks used by the sorted key table controller.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_KEY_TABLE_MACROS_SVH
`define SORTED_UNIQUE_KEY_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SUKT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted table check failed");

// next-cycle implication
`define SUKT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted table check failed");

`else

`define SUKT_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define SUKT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/sukt_pkg.sv =====
// ----------------------------------------------------------------------------
// sukt_pkg: sorted key table package
// Sizes, codes and types shared by the cell row, the controller and the top.
// ----------------------------------------------------------------------------
package sukt_pkg;

    // table geometry
    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_BITS     = 16;
    localparam int FILL_BITS    = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef logic [KEY_BITS-1:0]     key_t;
    typedef logic [PAYLOAD_BITS-1:0] slot_pl_t;
    typedef logic [FILL_BITS-1:0]    fill_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_e;

    // request transfer
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key;
        logic [31:0] payload;
    } req_t;

    // result transfer
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_key;
        logic [31:0] out_payload;
        logic [4:0]  entries_held;
    } rsp_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic pop;
    } cell_cmd_t;

    // lookup results gathered from the cell row
    typedef struct packed {
        logic     found;
        key_t     match_key;
        slot_pl_t match_pl;
        key_t     head_key;
        slot_pl_t head_pl;
    } hit_t;

    // port payload to stored payload width
    function automatic slot_pl_t pl_to_slot(input logic [31:0] v);
        logic [63:0] w;
        slot_pl_t    r;
        w = {32'd0, v};
        r = '0;
        for (int i = 0; i < PAYLOAD_BITS; i++) begin
            r[i] = w[i];
        end
        return r;
    endfunction

    // stored payload to port payload width
    function automatic logic [31:0] slot_to_pl(input slot_pl_t s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < PAYLOAD_BITS; i++) begin
            w[i] = s[i];
        end
        return w[31:0];
    endfunction

    // fill count to reported entry count
    function automatic logic [4:0] fill_to_held(input fill_t f);
        logic [15:0] w;
        w = 16'(f);
        return w[4:0];
    endfunction

endpackage

// ===== rtl/sorted_unique_key_table.sv =====
// Timing: a request taken at a start edge is decided and applied while busy is
//   high; its result is registered and strobes on done in the cycle after that.
// Issue: a new request is taken only while busy is low; busy is high for the
//   one cycle in which the cell row compares every slot and shifts in a single step.
// Reset: asynchronous, clears the fill count so the table reads empty; slot
//   contents are not reset and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_unique_key_table: bounded sorted table with unique keys
// A row of cells kept in ascending key order, supporting insert, remove by
// key and pop of the smallest entry, one result per request.
// ----------------------------------------------------------------------------
module sorted_unique_key_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sukt_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output sukt_pkg::rsp_t rsp
);

    sukt_pkg::cell_cmd_t cmd;
    sukt_pkg::key_t      bcast_key;
    sukt_pkg::slot_pl_t  bcast_pl;
    sukt_pkg::fill_t     fill;
    sukt_pkg::hit_t      hit;

    logic               cell_lt  [sukt_pkg::DEPTH];
    logic               cell_eq  [sukt_pkg::DEPTH];
    logic               cell_vld [sukt_pkg::DEPTH];
    sukt_pkg::key_t     cell_key [sukt_pkg::DEPTH];
    sukt_pkg::slot_pl_t cell_pl  [sukt_pkg::DEPTH];

    // controller
    sukt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .hit       (hit),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cmd       (cmd),
        .bcast_key (bcast_key),
        .bcast_pl  (bcast_pl),
        .fill      (fill)
    );

    // cell row
    for (genvar i = 0; i < sukt_pkg::DEPTH; i++)
    begin : g_cell
        logic               left_lt;
        sukt_pkg::key_t     left_key;
        sukt_pkg::slot_pl_t left_pl;
        sukt_pkg::key_t     right_key;
        sukt_pkg::slot_pl_t right_pl;

        assign cell_vld[i] = (sukt_pkg::FILL_BITS'(i) < fill);

        if (i == 0)
        begin : g_head
            assign left_lt  = 1'b1;
            assign left_key = cell_key[i];
            assign left_pl  = cell_pl[i];
        end
        else
        begin : g_body
            assign left_lt  = cell_lt[i-1];
            assign left_key = cell_key[i-1];
            assign left_pl  = cell_pl[i-1];
        end

        if (i == sukt_pkg::DEPTH - 1)
        begin : g_tail
            assign right_key = cell_key[i];
            assign right_pl  = cell_pl[i];
        end
        else
        begin : g_link
            assign right_key = cell_key[i+1];
            assign right_pl  = cell_pl[i+1];
        end

        sukt_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .valid     (cell_vld[i]),
            .new_key   (bcast_key),
            .new_pl    (bcast_pl),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .left_pl   (left_pl),
            .right_key (right_key),
            .right_pl  (right_pl),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i]),
            .key       (cell_key[i]),
            .pl        (cell_pl[i])
        );
    end

    // gather the matching slot and the head slot
    always_comb
    begin
        hit = '0;
        for (int i = 0; i < sukt_pkg::DEPTH; i++)
        begin
            hit.found     = hit.found | cell_eq[i];
            hit.match_key = hit.match_key | (cell_eq[i] ? cell_key[i] : '0);
            hit.match_pl  = hit.match_pl | (cell_eq[i] ? cell_pl[i] : '0);
        end
        hit.head_key = cell_key[0];
        hit.head_pl  = cell_pl[0];
    end

endmodule

// ===== rtl/sukt_cell.sv =====
// ----------------------------------------------------------------------------
// sukt_cell: one slot of the sorted table
// Compares its key with the broadcast key and takes new data, its left or
// its right neighbor's entry, or holds, as the shift command directs.
// ----------------------------------------------------------------------------
module sukt_cell (
    input  logic                clk,
    input  sukt_pkg::cell_cmd_t cmd,
    input  logic                valid,
    input  sukt_pkg::key_t      new_key,
    input  sukt_pkg::slot_pl_t  new_pl,
    input  logic                left_lt,
    input  sukt_pkg::key_t      left_key,
    input  sukt_pkg::slot_pl_t  left_pl,
    input  sukt_pkg::key_t      right_key,
    input  sukt_pkg::slot_pl_t  right_pl,
    output logic                lt,
    output logic                eq,
    output sukt_pkg::key_t      key,
    output sukt_pkg::slot_pl_t  pl
);

    sukt_pkg::key_t     key_reg;
    sukt_pkg::key_t     key_next;
    sukt_pkg::slot_pl_t pl_reg;
    sukt_pkg::slot_pl_t pl_next;
    logic               ge;

    // compare against the broadcast key
    always_comb
    begin
        lt = valid && (key_reg < new_key);
        eq = valid && (key_reg == new_key);
        ge = valid && !lt;
    end

    // pick the next entry for this slot
    always_comb
    begin
        key_next = key_reg;
        pl_next  = pl_reg;
        priority if (cmd.ins)
        begin
            if (!lt)
            begin
                if (left_lt)
                begin
                    key_next = new_key;
                    pl_next  = new_pl;
                end
                else
                begin
                    key_next = left_key;
                    pl_next  = left_pl;
                end
            end
        end
        else if (cmd.rem)
        begin
            if (ge)
            begin
                key_next = right_key;
                pl_next  = right_pl;
            end
        end
        else if (cmd.pop)
        begin
            key_next = right_key;
            pl_next  = right_pl;
        end
    end

    // slot storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pl_reg  <= pl_next;
    end

    assign key = key_reg;
    assign pl  = pl_reg;

endmodule

// ===== rtl/sukt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sukt_ctrl: sorted table controller
// Captures a request, decides the operation from the cell lookup, issues the
// shift command, tracks the fill count and registers the result.
// ----------------------------------------------------------------------------
`include "sorted_unique_key_table_macros.svh"

module sukt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sukt_pkg::req_t      req,
    input  sukt_pkg::hit_t      hit,
    output logic                busy,
    output logic                done,
    output sukt_pkg::rsp_t      rsp,
    output sukt_pkg::cell_cmd_t cmd,
    output sukt_pkg::key_t      bcast_key,
    output sukt_pkg::slot_pl_t  bcast_pl,
    output sukt_pkg::fill_t     fill
);

    sukt_pkg::state_e state_reg;
    sukt_pkg::state_e state_next;
    sukt_pkg::fill_t  fill_reg;
    sukt_pkg::fill_t  fill_next;
    logic             done_reg;
    logic             done_next;
    sukt_pkg::req_t   req_reg;
    sukt_pkg::rsp_t   rsp_reg;
    sukt_pkg::rsp_t   rsp_next;
    logic             accept;
    logic             table_full;
    logic             table_empty;

    assign accept      = start && (state_reg == sukt_pkg::S_IDLE);
    assign table_full  = (fill_reg == sukt_pkg::FILL_BITS'(sukt_pkg::DEPTH));
    assign table_empty = (fill_reg == '0);

    // next state, shift command and result
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        done_next  = 1'b0;
        cmd        = '0;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            sukt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sukt_pkg::S_EXEC;
                end
            end
            sukt_pkg::S_EXEC:
            begin
                state_next           = sukt_pkg::S_IDLE;
                done_next            = 1'b1;
                rsp_next.status      = sukt_pkg::ST_OK;
                rsp_next.out_key     = '0;
                rsp_next.out_payload = '0;
                unique case (req_reg.op)
                    sukt_pkg::OP_INSERT:
                    begin
                        if (hit.found)
                        begin
                            rsp_next.status = sukt_pkg::ST_DUP;
                        end
                        else if (table_full)
                        begin
                            rsp_next.status = sukt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.ins   = 1'b1;
                            fill_next = fill_reg + sukt_pkg::FILL_BITS'(1);
                        end
                    end
                    sukt_pkg::OP_REMOVE:
                    begin
                        if (table_empty)
                        begin
                            rsp_next.status = sukt_pkg::ST_EMPTY;
                        end
                        else if (hit.found)
                        begin
                            cmd.rem              = 1'b1;
                            fill_next            = fill_reg - sukt_pkg::FILL_BITS'(1);
                            rsp_next.out_key     = hit.match_key;
                            rsp_next.out_payload = sukt_pkg::slot_to_pl(hit.match_pl);
                        end
                        else
                        begin
                            rsp_next.status = sukt_pkg::ST_NOTFOUND;
                        end
                    end
                    sukt_pkg::OP_POP:
                    begin
                        if (table_empty)
                        begin
                            rsp_next.status = sukt_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop              = 1'b1;
                            fill_next            = fill_reg - sukt_pkg::FILL_BITS'(1);
                            rsp_next.out_key     = hit.head_key;
                            rsp_next.out_payload = sukt_pkg::slot_to_pl(hit.head_pl);
                        end
                    end
                    default:
                    begin
                        rsp_next.status = sukt_pkg::ST_OK;
                    end
                endcase
                rsp_next.entries_held = sukt_pkg::fill_to_held(fill_next);
            end
            default:
            begin
                state_next = sukt_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sukt_pkg::S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign busy      = (state_reg == sukt_pkg::S_EXEC);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign bcast_key = req_reg.key;
    assign bcast_pl  = sukt_pkg::pl_to_slot(req_reg.payload);
    assign fill      = fill_reg;

    // checks
    `SUKT_ASSERT_NEXT(a_exec_strobes, clk, rst_n, state_reg == sukt_pkg::S_EXEC, done_reg)
    `SUKT_ASSERT_NEXT(a_single_strobe, clk, rst_n, done_reg, !done_reg)
    `SUKT_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.ins, fill_reg == sukt_pkg::FILL_BITS'($past(fill_reg) + 1'b1))
    `SUKT_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, cmd.rem || cmd.pop, fill_reg == sukt_pkg::FILL_BITS'($past(fill_reg) - 1'b1))
    `SUKT_ASSERT_IMPLY(a_fill_bounded, clk, rst_n, done_reg, fill_reg <= sukt_pkg::FILL_BITS'(sukt_pkg::DEPTH))

endmodule
